// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_VALUE_BITS    = 32;
    localparam int SPQ_PRIO_IN_BITS  = 8;
    localparam int SPQ_OCC_BITS      = 5;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                          op;
        logic signed [SPQ_VALUE_BITS-1:0]    value;
        logic [SPQ_PRIO_IN_BITS-1:0]         priority_req;
    } spq_req_t;

    typedef struct packed {
        logic signed [SPQ_VALUE_BITS-1:0]    head_value;
        logic [SPQ_OCC_BITS-1:0]             occupancy;
        logic [1:0]                          status;
    } spq_rsp_t;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } spq_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One storage cell of the shift-register queue: holds one entry.
module spq_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                    clk,
    input  spq_pkg::spq_cmd_t                       cmd,
    input  logic                                    occupied,
    input  logic signed [spq_pkg::SPQ_VALUE_BITS-1:0] new_value,
    input  logic [PRIORITY_BITS-1:0]                new_prio,
    input  logic signed [spq_pkg::SPQ_VALUE_BITS-1:0] left_value,
    input  logic [PRIORITY_BITS-1:0]                left_prio,
    input  logic                                    left_ge,
    input  logic signed [spq_pkg::SPQ_VALUE_BITS-1:0] right_value,
    input  logic [PRIORITY_BITS-1:0]                right_prio,
    output logic signed [spq_pkg::SPQ_VALUE_BITS-1:0] value,
    output logic [PRIORITY_BITS-1:0]                prio,
    output logic                                    ge
);
    import spq_pkg::*;

    logic signed [SPQ_VALUE_BITS-1:0] value_reg;
    logic signed [SPQ_VALUE_BITS-1:0] value_next;
    logic [PRIORITY_BITS-1:0]         prio_reg;
    logic [PRIORITY_BITS-1:0]         prio_next;

    // entries at or above the new priority stay put; equal priorities keep arrival order
    assign ge    = occupied && (prio_reg >= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.push_en)
        begin
            if (!ge)
            begin
                if (left_ge)
                begin
                    value_next = new_value;
                    prio_next  = new_prio;
                end
                else
                begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end
            end
        end
        else if (cmd.pop_en)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue: top level with count, control and result register.
//
// Usage: requests enter on req (req_valid/req_ready), one beat per operation:
// push, pop head or clear. Every request yields exactly one response beat on
// rsp (rsp_valid/rsp_ready) with the popped word, the occupancy after the
// operation and a status code.
// Storage is a row of CAPACITY cells. On a push every cell compares its
// priority with the new one in parallel and the entries behind the insertion
// point move one cell along; on a pop the whole row moves one cell towards the
// head.
// Latency: the response is registered and appears the cycle after the request
// beat. Throughput: one request per cycle while rsp_ready stays high.
// When the receiver stalls, the pending response is held and req_ready drops
// until it is taken; nothing is lost or reordered.
// Reset empties the queue (count to zero); cell contents are left as they
// are and are never read before being written.
// A push to a full queue is dropped with status full; a pop on an empty queue
// returns zero with status empty.
module sorted_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  spq_pkg::spq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    spq_rsp_t       rsp_reg;
    spq_rsp_t       rsp_next;

    logic           accept;
    logic           full;
    logic           empty;
    spq_cmd_t       cmd;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [SPQ_OCC_BITS-1:0]  occ_next;

    logic signed [SPQ_VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [PRIORITY_BITS-1:0]         cell_prio  [CAPACITY];
    logic                             cell_ge    [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign cmd.push_en = accept && (req.op == OP_PUSH) && !full;
    assign cmd.pop_en  = accept && (req.op == OP_POP) && !empty;

    generate
        if (PRIORITY_BITS >= SPQ_PRIO_IN_BITS)
        begin : g_prio_wide
            assign new_prio = PRIORITY_BITS'(req.priority_req);
        end
        else
        begin : g_prio_narrow
            assign new_prio = req.priority_req[PRIORITY_BITS-1:0];
        end

        if (CW >= SPQ_OCC_BITS)
        begin : g_occ_trunc
            assign occ_next = count_next[SPQ_OCC_BITS-1:0];
        end
        else
        begin : g_occ_ext
            assign occ_next = SPQ_OCC_BITS'(count_next);
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [SPQ_VALUE_BITS-1:0] left_value;
            logic [PRIORITY_BITS-1:0]         left_prio;
            logic                             left_ge;
            logic signed [SPQ_VALUE_BITS-1:0] right_value;
            logic [PRIORITY_BITS-1:0]         right_prio;

            if (i == 0)
            begin : g_head
                assign left_value = req.value;
                assign left_prio  = new_prio;
                assign left_ge    = 1'b1;
            end
            else
            begin : g_body
                assign left_value = cell_value[i-1];
                assign left_prio  = cell_prio[i-1];
                assign left_ge    = cell_ge[i-1];
            end

            // tail cell refills from itself on a pop; its content is beyond the count then
            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_value = cell_value[i];
                assign right_prio  = cell_prio[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
                assign right_prio  = cell_prio[i+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (count_reg > CW'(i)),
                .new_value   (req.value),
                .new_prio    (new_prio),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .left_ge     (left_ge),
                .right_value (right_value),
                .right_prio  (right_prio),
                .value       (cell_value[i]),
                .prio        (cell_prio[i]),
                .ge          (cell_ge[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        rsp_next.head_value = '0;
        rsp_next.status     = ST_OK;
        case (req.op)
            OP_PUSH:
            begin
                if (full)
                    rsp_next.status = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            OP_POP:
            begin
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else
                begin
                    count_next          = count_reg - 1'b1;
                    rsp_next.head_value = cell_value[0];
                end
            end
            OP_CLEAR:
                count_next = '0;
            default:
                count_next = count_reg;
        endcase
        if (!accept)
            count_next = count_reg;
        rsp_next.occupancy = occ_next;
        if (!accept)
            rsp_next = rsp_reg;

        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("queue count above capacity");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_en |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shorten the queue");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == OP_PUSH && full |=> $stable(count_reg) && rsp.status == ST_FULL)
        else $error("push to full queue not dropped");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == OP_CLEAR |=> count_reg == '0)
        else $error("clear left entries behind");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.head_value == '0)
        else $error("empty pop returned a word");

endmodule

// ===== tb/sorted_priority_queue_test.sv =====
// Self-checking testbench for the sorted priority queue: directed and random beats.
`timescale 1ns / 1ps

module sorted_priority_queue_test;

    import spq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_OFF      = 80;

    // op code with no defined operation; the block treats it as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Shadow copy of the queue contents; predicts one response per request beat.
    class queue_shadow;
        logic signed [SPQ_VALUE_BITS-1:0] slot_value [CAPACITY];
        logic [PRIORITY_BITS-1:0]         slot_prio [CAPACITY];
        int                               held;
        spq_rsp_t                         awaited [$];
        int errors;
        int n_push, n_pop, n_clear, n_noop, n_full, n_empty;

        function new();
            held   = 0;
            errors = 0;
            n_push = 0; n_pop = 0; n_clear = 0; n_noop = 0; n_full = 0; n_empty = 0;
        endfunction

        function void accept_request(spq_req_t r);
            spq_rsp_t                 want;
            logic [PRIORITY_BITS-1:0] prio;
            int                       pos;
            want = '0;
            want.status = ST_OK;
            prio = r.priority_req[PRIORITY_BITS-1:0];
            case (r.op)
                OP_PUSH:
                begin
                    n_push++;
                    if (held >= CAPACITY)
                    begin
                        want.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        // equal priorities keep arrival order
                        pos = 0;
                        while (pos < held && slot_prio[pos] >= prio)
                            pos++;
                        for (int i = held; i > pos; i--)
                        begin
                            slot_value[i] = slot_value[i-1];
                            slot_prio[i]  = slot_prio[i-1];
                        end
                        slot_value[pos] = r.value;
                        slot_prio[pos]  = prio;
                        held++;
                    end
                end
                OP_POP:
                begin
                    n_pop++;
                    if (held == 0)
                    begin
                        want.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        want.head_value = slot_value[0];
                        for (int i = 1; i < held; i++)
                        begin
                            slot_value[i-1] = slot_value[i];
                            slot_prio[i-1]  = slot_prio[i];
                        end
                        held--;
                    end
                end
                OP_CLEAR:
                begin
                    n_clear++;
                    held = 0;
                end
                default:
                    n_noop++;
            endcase
            want.occupancy = SPQ_OCC_BITS'(held);
            awaited.push_back(want);
        endfunction

        function void check_response(spq_rsp_t got);
            spq_rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected response: head_value %h occupancy %0d status %0d",
                       got.head_value, got.occupancy, got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.head_value !== want.head_value)
            begin
                $error("head_value: expected %h, got %h", want.head_value, got.head_value);
                errors++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    spq_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    spq_rsp_t rsp;

    queue_shadow shadow;
    int          beats_out;

    sorted_priority_queue #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic spq_req_t make_req(logic [1:0] op, logic [31:0] val,
                                          logic [7:0] prio);
        spq_req_t r;
        r.op           = op;
        r.value        = val;
        r.priority_req = prio;
        return r;
    endfunction

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // op mix drifts between filling, draining and balanced phases
    function automatic spq_req_t random_request(int idx);
        int          roll;
        int          push_pct;
        logic [31:0] val;
        logic [7:0]  prio;
        case ((idx / 40) % 3)
            0:       push_pct = 80;
            1:       push_pct = 30;
            default: push_pct = 55;
        endcase
        val  = $urandom;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            val = 32'h8000_0000;
        else if (roll == 1)
            val = 32'h7fff_ffff;
        if ($urandom_range(0, 1))
            prio = 8'($urandom_range(0, 255));
        else
            prio = 8'($urandom_range(0, 3));   // crowded priorities, lots of ties
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return make_req(OP_CLEAR, val, prio);
        if (roll < 4)
            return make_req(OP_UNUSED, val, prio);
        if (roll < 4 + push_pct)
            return make_req(OP_PUSH, val, prio);
        return make_req(OP_POP, val, prio);
    endfunction

    task automatic send_request(input spq_req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.accept_request(r);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
    endtask

    // response side: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int  stall_left;
        int  cycle;
        bit  held_off;
        stall_left = 0;
        cycle      = 0;
        held_off   = 1'b0;
        rsp_ready  <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rsp_valid && rsp_ready)
            begin
                shadow.check_response(rsp);
                beats_out++;
            end
            if (!held_off && beats_out >= 120)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF;
            end
            else if (stall_left == 0 && ((cycle / 128) % 4) != 1)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
            cycle++;
            @(posedge clk);
        end
    end

    // watchdog: cycles without any beat on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        spq_req_t directed [$];
        shadow    = new();
        beats_out = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // empty queue corners, unused op code, then a fill with ties and extremes past capacity, pops and a clear
        directed.push_back(make_req(OP_POP,   32'h1234_5678, 8'd9));
        directed.push_back(make_req(OP_CLEAR, 32'hffff_ffff, 8'hff));
        directed.push_back(make_req(OP_UNUSED, 32'hdead_beef, 8'd1));
        directed.push_back(make_req(OP_PUSH,  32'h8000_0000, 8'd0));
        directed.push_back(make_req(OP_PUSH,  32'h7fff_ffff, 8'd255));
        directed.push_back(make_req(OP_PUSH,  32'hffff_ffff, 8'd128));
        directed.push_back(make_req(OP_PUSH,  32'h0000_0000, 8'd128));
        directed.push_back(make_req(OP_PUSH,  32'h0000_0001, 8'd128));
        directed.push_back(make_req(OP_PUSH,  32'h5555_5555, 8'h55));
        directed.push_back(make_req(OP_PUSH,  32'haaaa_aaaa, 8'haa));
        directed.push_back(make_req(OP_PUSH,  32'h0000_0002, 8'd255));
        directed.push_back(make_req(OP_PUSH,  32'h0000_0003, 8'd0));
        for (int i = 0; i < 7; i++)
            directed.push_back(make_req(OP_PUSH, 32'h100 + i, 8'(i * 37)));
        directed.push_back(make_req(OP_PUSH,  32'hcafe_f00d, 8'd255));
        directed.push_back(make_req(OP_UNUSED, 32'h0,        8'd0));
        for (int i = 0; i < 3; i++)
            directed.push_back(make_req(OP_POP, 32'h0, 8'd0));
        directed.push_back(make_req(OP_CLEAR, 32'h0, 8'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_request(directed[i]);
            sender_gap(pick_gap());
        end
        drain_responses();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_request(random_request(i));
            if (i == 300)
                drain_responses();
            else if (i < 80 || i > 140)
                sender_gap(pick_gap());
        end
        drain_responses();
        repeat (4) @(posedge clk);

        $display("Ran %0d requests: %0d push, %0d pop, %0d clear, %0d unused op.",
                 shadow.n_push + shadow.n_pop + shadow.n_clear + shadow.n_noop,
                 shadow.n_push, shadow.n_pop, shadow.n_clear, shadow.n_noop);
        $display("Pushes refused when full: %0d; pops on an empty queue: %0d; mismatches: %0d.",
                 shadow.n_full, shadow.n_empty, shadow.errors);
        if (shadow.errors == 0 && shadow.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
